/* sv/awpc_pkg.sv */
// ----------------------------------------------------------------------------
// awpc_pkg
// Shared types and constants for the alpha weight pixel clamp block.
// ----------------------------------------------------------------------------
`default_nettype none

package awpc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int NUM_BANDS = 3;
    localparam int BCNT_W    = 2;
    localparam int DIV_CELLS = SAMPLE_W;
    localparam int NUM_STAGES = DIV_CELLS + 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    localparam logic [BCNT_W-1:0]   RST_BAND_COUNT = 2'd3;
    localparam logic                RST_WIDE       = 1'b0;
    localparam logic                RST_SWAP       = 1'b0;
    localparam logic [SAMPLE_W-1:0] RST_ALPHA_MAX  = 16'd255;
    localparam logic [SAMPLE_W-1:0] RST_MIN_VALUE  = 16'd1;
    localparam logic [SAMPLE_W-1:0] RST_MAX_VALUE  = 16'd255;
    localparam logic [SAMPLE_W-1:0] RST_NULL_VALUE = 16'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_BAND_COUNT = 3'd0,
        REG_WIDE       = 3'd1,
        REG_SWAP       = 3'd2,
        REG_ALPHA_MAX  = 3'd3,
        REG_MIN_VALUE  = 3'd4,
        REG_MAX_VALUE  = 3'd5,
        REG_NULL_VALUE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [BCNT_W-1:0]   band_count;
        logic                wide;
        logic                swap;
        logic [SAMPLE_W-1:0] alpha_max;
        logic [SAMPLE_W-1:0] min_value;
        logic [SAMPLE_W-1:0] max_value;
        logic [SAMPLE_W-1:0] null_value;
    } t_cfg;

    // Word after sample prep and multiply.
    typedef struct packed {
        logic [NUM_BANDS-1:0][SAMPLE_W-1:0] smp;
        logic [NUM_BANDS-1:0][PROD_W-1:0]   prod;
        logic                               a_full;
        logic                               a_zero;
    } t_prep;

    // One band as it travels down the divider row.
    typedef struct packed {
        logic                spec;
        logic [SAMPLE_W-1:0] val;
        logic [PROD_W-1:0]   rem;
        logic [SAMPLE_W-1:0] quo;
    } t_band;

endpackage

`default_nettype wire

/* sv/awpc_pix_if.sv */
// ----------------------------------------------------------------------------
// awpc_pix_if
// Input pixel channel: colour samples and alpha with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface awpc_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] chan0;
    logic [15:0] chan1;
    logic [15:0] chan2;
    logic [15:0] alpha_in;

    modport source (output valid, output chan0, output chan1, output chan2,
                    output alpha_in, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2,
                    input alpha_in, output ready);
endinterface

`default_nettype wire

/* sv/awpc_res_if.sv */
// ----------------------------------------------------------------------------
// awpc_res_if
// Result channel: weighted bands with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface awpc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] out0;
    logic [15:0] out1;
    logic [15:0] out2;

    modport source (output valid, output out0, output out1, output out2,
                    input ready);
    modport sink   (input valid, input out0, input out1, input out2,
                    output ready);
endinterface

`default_nettype wire

/* sv/awpc_prep.sv */
// ----------------------------------------------------------------------------
// awpc_prep
// Sample prep (width select, byte swap) and per-band sample*alpha multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module awpc_prep import awpc_pkg::*; (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  t_cfg                                i_cfg,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [NUM_BANDS-1:0][SAMPLE_W-1:0]  i_chan,
    input  wire  [SAMPLE_W-1:0]                 i_alpha,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output t_prep                               o_prep
);

    logic          r_valid;
    t_prep         r_prep;
    t_prep         n_prep;
    logic [SAMPLE_W-1:0] w_alpha;

    function automatic logic [SAMPLE_W-1:0] prep_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic                wide,
        input logic                swap
    );
        logic [SAMPLE_W-1:0] s;
        s = raw;
        if (!wide) begin
            s = {8'h00, raw[7:0]};
        end else if (swap) begin
            s = {raw[7:0], raw[15:8]};
        end
        return s;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prep  = r_prep;

    always_comb begin
        w_alpha       = prep_sample(i_alpha, i_cfg.wide, i_cfg.swap);
        n_prep.a_full = (w_alpha == i_cfg.alpha_max);
        n_prep.a_zero = (w_alpha == '0);
        for (int k = 0; k < NUM_BANDS; k++) begin
            n_prep.smp[k]  = prep_sample(i_chan[k], i_cfg.wide, i_cfg.swap);
            n_prep.prod[k] = PROD_W'(n_prep.smp[k]) * PROD_W'(w_alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_prep <= n_prep;
        end
    end

endmodule

`default_nettype wire

/* sv/awpc_sort.sv */
// ----------------------------------------------------------------------------
// awpc_sort
// Sort each band into a fixed answer or a quotient for the divider row.
// ----------------------------------------------------------------------------
`default_nettype none

module awpc_sort import awpc_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cfg                    i_cfg,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  t_prep                   i_prep,
    output logic                    o_valid,
    input  wire                     i_ready,
    output t_band [NUM_BANDS-1:0]   o_band
);

    logic                  r_valid;
    t_band [NUM_BANDS-1:0] r_band;
    t_band [NUM_BANDS-1:0] n_band;
    logic [PROD_W-1:0]     r_null_prod;
    logic [PROD_W-1:0]     w_sat_lim;

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_band    = r_band;
    assign w_sat_lim = {i_cfg.alpha_max, {SAMPLE_W{1'b0}}};

    // Quotients of 2^16 and up always clamp to max, so saturate them here.
    always_comb begin
        for (int k = 0; k < NUM_BANDS; k++) begin
            n_band[k].rem  = i_prep.prod[k];
            n_band[k].quo  = '0;
            n_band[k].spec = 1'b1;
            n_band[k].val  = i_cfg.max_value;
            priority if (i_prep.a_full) begin
                n_band[k].val = i_prep.smp[k];
            end else if (i_prep.a_zero) begin
                n_band[k].val = i_cfg.null_value;
            end else if (i_cfg.alpha_max == '0) begin
                n_band[k].val = i_cfg.max_value;
            end else if (i_prep.prod[k] == r_null_prod) begin
                n_band[k].val = i_cfg.null_value;
            end else if (i_prep.prod[k] >= w_sat_lim) begin
                n_band[k].val = i_cfg.max_value;
            end else begin
                n_band[k].spec = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_null_prod <= PROD_W'(i_cfg.null_value) * PROD_W'(i_cfg.alpha_max);
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_band <= n_band;
        end
    end

endmodule

`default_nettype wire

/* sv/awpc_div_cell.sv */
// ----------------------------------------------------------------------------
// awpc_div_cell
// One restoring-division cell: settles one quotient bit for every band not marked special.
// ----------------------------------------------------------------------------
`default_nettype none

module awpc_div_cell import awpc_pkg::*; #(
    parameter int unsigned BitIdx = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cfg                    i_cfg,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  t_band [NUM_BANDS-1:0]   i_band,
    output logic                    o_valid,
    input  wire                     i_ready,
    output t_band [NUM_BANDS-1:0]   o_band
);

    logic                  r_valid;
    t_band [NUM_BANDS-1:0] r_band;
    t_band [NUM_BANDS-1:0] n_band;
    logic [PROD_W-1:0]     w_div;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_band  = r_band;
    assign w_div   = PROD_W'(i_cfg.alpha_max) << BitIdx;

    always_comb begin
        n_band = i_band;
        for (int k = 0; k < NUM_BANDS; k++) begin
            if (!i_band[k].spec && (i_band[k].rem >= w_div)) begin
                n_band[k].rem         = i_band[k].rem - w_div;
                n_band[k].quo[BitIdx] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_band <= n_band;
        end
    end

endmodule

`default_nettype wire

/* sv/awpc_clamp.sv */
// ----------------------------------------------------------------------------
// awpc_clamp
// Clamp quotients to [min,max], mask for 8-bit mode, zero unused bands.
// ----------------------------------------------------------------------------
`default_nettype none

module awpc_clamp import awpc_pkg::*; (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  t_cfg                                i_cfg,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  t_band [NUM_BANDS-1:0]               i_band,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [NUM_BANDS-1:0][SAMPLE_W-1:0]  o_out
);

    logic                               r_valid;
    logic [NUM_BANDS-1:0][SAMPLE_W-1:0] r_out;
    logic [NUM_BANDS-1:0][SAMPLE_W-1:0] n_out;
    logic [SAMPLE_W-1:0]                w_v;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    always_comb begin
        w_v = '0;
        for (int k = 0; k < NUM_BANDS; k++) begin
            priority if (i_band[k].spec) begin
                w_v = i_band[k].val;
            end else if (i_band[k].quo < i_cfg.min_value) begin
                w_v = i_cfg.min_value;
            end else if (i_band[k].quo > i_cfg.max_value) begin
                w_v = i_cfg.max_value;
            end else begin
                w_v = i_band[k].quo;
            end
            if (!i_cfg.wide) begin
                w_v[SAMPLE_W-1:8] = '0;
            end
            n_out[k] = (BCNT_W'(k) < i_cfg.band_count) ? w_v : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* sv/alpha_weight_pixel_clamp.sv */
// Pipeline: each accepted pixel word is registered in turn by prep/multiply,
//   sort, 16 divider cells and clamp before it leaves as a result word.
// Throughput: one pixel word per clock unless the output stalls; each cell
//   has a valid bit and takes a new word when empty or its neighbor moves on.
// Reset: i_rst_n synchronous, active low; clears all valid bits and loads
//   the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// alpha_weight_pixel_clamp
// Alpha premultiply of one interleaved pixel with null handling and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_weight_pixel_clamp import awpc_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    awpc_pix_if.sink             i_pix,
    awpc_res_if.source           o_pix,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [ADDR_W-1:0]    paddr,
    input  wire  [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    // Handshake links: link j feeds stage j, link NUM_STAGES is the output.
    logic [NUM_STAGES:0] w_vld;
    logic [NUM_STAGES:0] w_rdy;

    t_prep                              w_prep;
    t_band [NUM_BANDS-1:0]              w_band [DIV_CELLS+1];
    logic [NUM_BANDS-1:0][SAMPLE_W-1:0] w_out;
    logic [NUM_BANDS-1:0][SAMPLE_W-1:0] w_chan;

    logic [CNT_W-1:0] r_inflight;

    // ------------------------------------------------------------------
    // Register file. Writes land on the access phase; reads are direct.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_count <= RST_BAND_COUNT;
            r_cfg.wide       <= RST_WIDE;
            r_cfg.swap       <= RST_SWAP;
            r_cfg.alpha_max  <= RST_ALPHA_MAX;
            r_cfg.min_value  <= RST_MIN_VALUE;
            r_cfg.max_value  <= RST_MAX_VALUE;
            r_cfg.null_value <= RST_NULL_VALUE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BAND_COUNT: r_cfg.band_count <= pwdata[BCNT_W-1:0];
                REG_WIDE:       r_cfg.wide       <= pwdata[0];
                REG_SWAP:       r_cfg.swap       <= pwdata[0];
                REG_ALPHA_MAX:  r_cfg.alpha_max  <= pwdata[SAMPLE_W-1:0];
                REG_MIN_VALUE:  r_cfg.min_value  <= pwdata[SAMPLE_W-1:0];
                REG_MAX_VALUE:  r_cfg.max_value  <= pwdata[SAMPLE_W-1:0];
                REG_NULL_VALUE: r_cfg.null_value <= pwdata[SAMPLE_W-1:0];
                default: ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BAND_COUNT: prdata = DATA_W'(r_cfg.band_count);
            REG_WIDE:       prdata = DATA_W'(r_cfg.wide);
            REG_SWAP:       prdata = DATA_W'(r_cfg.swap);
            REG_ALPHA_MAX:  prdata = DATA_W'(r_cfg.alpha_max);
            REG_MIN_VALUE:  prdata = DATA_W'(r_cfg.min_value);
            REG_MAX_VALUE:  prdata = DATA_W'(r_cfg.max_value);
            REG_NULL_VALUE: prdata = DATA_W'(r_cfg.null_value);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Channel edges.
    // ------------------------------------------------------------------
    assign w_vld[0]           = i_pix.valid;
    assign i_pix.ready        = w_rdy[0];
    assign o_pix.valid        = w_vld[NUM_STAGES];
    assign w_rdy[NUM_STAGES]  = o_pix.ready;
    assign o_pix.out0         = w_out[0];
    assign o_pix.out1         = w_out[1];
    assign o_pix.out2         = w_out[2];
    assign w_chan[0]          = i_pix.chan0;
    assign w_chan[1]          = i_pix.chan1;
    assign w_chan[2]          = i_pix.chan2;

    // ------------------------------------------------------------------
    // Cell row: prep/multiply, sort, one divider cell per quotient bit
    // (most significant first), clamp/output register.
    // ------------------------------------------------------------------
    awpc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_vld[0]),
        .o_ready (w_rdy[0]),
        .i_chan  (w_chan),
        .i_alpha (i_pix.alpha_in),
        .o_valid (w_vld[1]),
        .i_ready (w_rdy[1]),
        .o_prep  (w_prep)
    );

    awpc_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_vld[1]),
        .o_ready (w_rdy[1]),
        .i_prep  (w_prep),
        .o_valid (w_vld[2]),
        .i_ready (w_rdy[2]),
        .o_band  (w_band[0])
    );

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        awpc_div_cell #(
            .BitIdx (DIV_CELLS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_valid (w_vld[g+2]),
            .o_ready (w_rdy[g+2]),
            .i_band  (w_band[g]),
            .o_valid (w_vld[g+3]),
            .i_ready (w_rdy[g+3]),
            .o_band  (w_band[g+1])
        );
    end

    awpc_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_vld[NUM_STAGES-1]),
        .o_ready (w_rdy[NUM_STAGES-1]),
        .i_band  (w_band[DIV_CELLS]),
        .o_valid (w_vld[NUM_STAGES]),
        .i_ready (w_rdy[NUM_STAGES]),
        .o_out   (w_out)
    );

    // ------------------------------------------------------------------
    // Words in flight: accepted in minus delivered out.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight
                        + CNT_W'(i_pix.valid && i_pix.ready)
                        - CNT_W'(o_pix.valid && o_pix.ready);
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_inflight_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == CNT_W'($countones(w_vld[NUM_STAGES:1])))
        else $error("word count in flight does not match cell valid bits");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_vld[NUM_STAGES:1] && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while every cell is full and output stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_pix.valid)
        else $error("result word shown right after reset");

    a_bubble_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_vld[1] |-> i_pix.ready)
        else $error("input blocked while first cell is empty");

endmodule

`default_nettype wire
